>>> hdl/assert_macros.svh
// assertion macros shared by the odometry rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/ddwo_pkg.sv
// types, constants and tables of the wheel odometry block
// used by ddwo_serial_alu and diff_drive_wheel_odometry
package ddwo_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_NOW, S_VL1, S_VL2, S_VL3, S_VR1, S_VR2, S_VR3,
    S_W1, S_W2, S_P, S_ANG, S_XINIT, S_CORDIC,
    S_PX1, S_PX2, S_PY1, S_PY2, S_DONE
  } state_e;

  typedef enum logic {
    AR_MUL,
    AR_DIV
  } ar_op_e;

  // command to the shared shift-add / subtract unit
  typedef struct packed {
    logic        start;
    ar_op_e      op;
    logic [63:0] a;
    logic [63:0] b;
  } ar_cmd_t;

  // status and result of the unit
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] hi;
    logic [63:0] lo;
  } ar_rsp_t;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_ID = 2'd0;
  localparam logic [1:0] CFG_DIAM     = 2'd1;
  localparam logic [1:0] CFG_TREAD    = 2'd2;

  localparam int unsigned AR_STEPS = 64;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_W = 40;

  localparam logic [63:0] PI_Q32     = 64'd13493037705;
  localparam logic [63:0] SPEED_DEN  = 64'd3932160000000;
  localparam logic [63:0] SPEED_HALF = 64'd1966080000000;
  localparam logic [63:0] KANG       = 64'd12609553696233680000;
  localparam logic [63:0] KINV_Q32   = 64'd2608131496;
  localparam logic [63:0] NS_PER_S   = 64'd1000000000;
  localparam logic [63:0] NS_HALF    = 64'd500000000;
  localparam logic [63:0] UM_PER_M   = 64'd1000000;

  // arctangent of 2^-i as binary angle
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/ddwo_serial_alu.sv
// bit-serial unsigned 64x64 multiplier and 64/64 restoring divider
// depends on ddwo_pkg for the command and result structs
module ddwo_serial_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddwo_pkg::ar_cmd_t cmd_i,
  output ddwo_pkg::ar_rsp_t rsp_o
);

  logic [6:0]          cnt_q, cnt_d;
  logic                done_q, done_d;
  ddwo_pkg::ar_op_e    op_q, op_d;
  logic [63:0]         hi_q, hi_d, lo_q, lo_d, b_q, b_d;
  logic [64:0]         sum, trial;

  // one multiplier bit or one quotient bit per cycle
  always_comb begin
    sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : 65'd0);
    trial = {hi_q, lo_q[63]};
    cnt_d = cnt_q;
    op_d  = op_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    b_d   = b_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      cnt_d = 7'(ddwo_pkg::AR_STEPS);
      op_d  = cmd_i.op;
      hi_d  = '0;
      lo_d  = cmd_i.a;
      b_d   = cmd_i.b;
    end else if (cnt_q != 7'd0) begin
      cnt_d  = cnt_q - 7'd1;
      done_d = (cnt_q == 7'd1);
      unique case (op_q)
        ddwo_pkg::AR_MUL: begin
          hi_d = sum[64:1];
          lo_d = {sum[0], lo_q[63:1]};
        end
        ddwo_pkg::AR_DIV: begin
          if (trial >= {1'b0, b_q}) begin
            hi_d = 64'(trial - {1'b0, b_q});
            lo_d = {lo_q[62:0], 1'b1};
          end else begin
            hi_d = trial[63:0];
            lo_d = {lo_q[62:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      op_q   <= ddwo_pkg::AR_MUL;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    b_q  <= b_d;
  end

  assign rsp_o.busy = (cnt_q != 7'd0);
  assign rsp_o.done = done_q;
  assign rsp_o.hi   = hi_q;
  assign rsp_o.lo   = lo_q;

endmodule

>>> hdl/diff_drive_wheel_odometry.sv
// differential-drive wheel odometry from CAN wheel-rpm frames
// depends on ddwo_pkg, ddwo_serial_alu and assert_macros.svh
//
// Input channel (in_valid_i/in_ready_o) takes one CAN frame request: id,
// left and right rpm and a timestamp. Frames whose id differs from the
// configured one are taken while idle and dropped with no result.
// A matching frame is worked through a sequencer around one shared
// bit-serial unit (16 multiplies or divides) and a 30-step CORDIC
// rotator, step by step from request to result.
// One frame is in work at a time; in_ready_o is high only while idle.
// The result request (out_valid_o/out_ready_i) carries pose, twist and
// the echoed stamp. It sits in an output register, so the next frame
// is taken while it waits; a finished frame holds in its last step
// until the previous result has been taken.
// Configuration writes (cfg_valid_i/cfg_ready_o) are always taken and
// should come only while the block is idle.
// Reset clears pose, heading and last stamp, marks the next frame as the
// first one (dt zero) and loads the default id, diameter and tread.
module diff_drive_wheel_odometry #(
  parameter int unsigned POSITION_BITS = 48,
  parameter int unsigned ANGLE_BITS    = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [28:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [28:0]                     can_id_i,
  input  logic [7:0]                      left_rpm_i,
  input  logic [7:0]                      right_rpm_i,
  input  logic [30:0]                     stamp_sec_i,
  input  logic [29:0]                     stamp_nsec_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [POSITION_BITS-1:0] pos_x_o,
  output logic signed [POSITION_BITS-1:0] pos_y_o,
  output logic signed [31:0]              heading_o,
  output logic signed [31:0]              vel_x_o,
  output logic signed [31:0]              vel_y_o,
  output logic signed [31:0]              yaw_rate_o,
  output logic [30:0]                     out_sec_o,
  output logic [29:0]                     out_nsec_o
);

  `include "assert_macros.svh"

  localparam int unsigned SH  = 48 - ANGLE_BITS;
  localparam int unsigned ASH = 32 - ANGLE_BITS;
  localparam int unsigned CW  = ddwo_pkg::CORDIC_W;
  localparam logic [63:0] SH_HALF = 64'd1 << (SH - 1);
  localparam logic signed [CW-1:0] CR_HALF = CW'(32768);

  ddwo_pkg::state_e state_q, state_d;
  ddwo_pkg::ar_cmd_t ar_cmd;
  ddwo_pkg::ar_rsp_t ar_rsp;
  logic go_q, go_d;

  // configuration
  logic [28:0] frame_id_q;
  logic [21:0] diam_q;
  logic [22:0] tread_q, tread_eff;

  // frame and working registers
  logic [30:0] sec_q;
  logic [29:0] nsec_q;
  logic [7:0]  rpm_l_q, rpm_r_q;
  logic [63:0] now_q, last_q, t_q;
  logic        first_q;
  logic [31:0] dt_mag_q;
  logic        dt_neg_q;
  logic [22:0] vl_q, vr_q, vave_q;
  logic        dw_neg_q, w_neg_q, sgn_q;
  logic [31:0] w_mag_q;
  logic signed [31:0] w_q, dx_q, dy_q;
  logic [ANGLE_BITS-1:0] heading_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic [4:0] cnt_q;
  logic signed [POSITION_BITS-1:0] pos_x_q, pos_y_q;

  // output register
  logic        out_valid_q;
  logic signed [31:0] o_head_q, o_vx_q, o_vy_q, o_w_q;
  logic [30:0] o_sec_q;
  logic [29:0] o_nsec_q;

  // derived values
  logic        id_match, out_free;
  logic [63:0] diff, r_full;
  logic [31:0] ang32, ang_rot, ang_adj;
  logic        flip;
  logic signed [CW-1:0] x0, dxs, dys, rnd_x, rnd_y;
  logic signed [32:0] at;
  logic signed [31:0] vx_w, vy_w;
  logic [31:0] vx_mag, vy_mag;
  logic [23:0] vsum;
  logic [63:0] wq;

  function automatic logic signed [POSITION_BITS-1:0] sat_add(
    input logic signed [POSITION_BITS-1:0] a,
    input logic signed [31:0] d
  );
    logic signed [POSITION_BITS:0] s;
    s = {a[POSITION_BITS-1], a} + (POSITION_BITS+1)'(d);
    if (s[POSITION_BITS] != s[POSITION_BITS-1]) begin
      return s[POSITION_BITS] ? {1'b1, {(POSITION_BITS-1){1'b0}}}
                              : {1'b0, {(POSITION_BITS-1){1'b1}}};
    end
    return s[POSITION_BITS-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ddwo_pkg::S_IDLE);
  assign id_match    = (can_id_i == frame_id_q);
  assign out_free    = !out_valid_q || out_ready_i;
  assign tread_eff   = (tread_q == 23'd0) ? 23'd1 : tread_q;

  // time step and heading rounding
  assign diff   = now_q - last_q;
  assign r_full = (ar_rsp.hi + SH_HALF) >> SH;

  // quadrant fold ahead of the rotator
  assign ang32   = 32'(heading_q) << ASH;
  assign ang_rot = ang32 + 32'h4000_0000;
  assign flip    = ang_rot[31];
  assign ang_adj = flip ? ang32 + 32'h8000_0000 : ang32;
  assign x0      = CW'((ar_rsp.lo + 64'd32768) >> 16);

  // one CORDIC micro-rotation
  assign dxs = cy_q >>> cnt_q;
  assign dys = cx_q >>> cnt_q;
  assign at  = 33'(ddwo_pkg::atan_lut(cnt_q));

  // rounded velocity from the rotator
  assign rnd_x  = cx_q + CR_HALF;
  assign rnd_y  = cy_q + CR_HALF;
  assign vx_w   = 32'(rnd_x >>> 16);
  assign vy_w   = 32'(rnd_y >>> 16);
  assign vx_mag = vx_w[31] ? 32'(-vx_w) : 32'(vx_w);
  assign vy_mag = vy_w[31] ? 32'(-vy_w) : 32'(vy_w);
  assign vsum   = 24'(vl_q) + 24'(vr_q) + 24'd1;
  assign wq     = ar_rsp.lo;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddwo_pkg::S_IDLE:   if (in_valid_i && id_match) state_d = ddwo_pkg::S_NOW;
      ddwo_pkg::S_NOW:    if (ar_rsp.done) state_d = ddwo_pkg::S_VL1;
      ddwo_pkg::S_VL1:    if (ar_rsp.done) state_d = ddwo_pkg::S_VL2;
      ddwo_pkg::S_VL2:    if (ar_rsp.done) state_d = ddwo_pkg::S_VL3;
      ddwo_pkg::S_VL3:    if (ar_rsp.done) state_d = ddwo_pkg::S_VR1;
      ddwo_pkg::S_VR1:    if (ar_rsp.done) state_d = ddwo_pkg::S_VR2;
      ddwo_pkg::S_VR2:    if (ar_rsp.done) state_d = ddwo_pkg::S_VR3;
      ddwo_pkg::S_VR3:    if (ar_rsp.done) state_d = ddwo_pkg::S_W1;
      ddwo_pkg::S_W1:     if (ar_rsp.done) state_d = ddwo_pkg::S_W2;
      ddwo_pkg::S_W2:     if (ar_rsp.done) state_d = ddwo_pkg::S_P;
      ddwo_pkg::S_P:      if (ar_rsp.done) state_d = ddwo_pkg::S_ANG;
      ddwo_pkg::S_ANG:    if (ar_rsp.done) state_d = ddwo_pkg::S_XINIT;
      ddwo_pkg::S_XINIT:  if (ar_rsp.done) state_d = ddwo_pkg::S_CORDIC;
      ddwo_pkg::S_CORDIC: begin
        if (cnt_q == 5'(ddwo_pkg::CORDIC_STEPS - 1)) state_d = ddwo_pkg::S_PX1;
      end
      ddwo_pkg::S_PX1:    if (ar_rsp.done) state_d = ddwo_pkg::S_PX2;
      ddwo_pkg::S_PX2:    if (ar_rsp.done) state_d = ddwo_pkg::S_PY1;
      ddwo_pkg::S_PY1:    if (ar_rsp.done) state_d = ddwo_pkg::S_PY2;
      ddwo_pkg::S_PY2:    if (ar_rsp.done) state_d = ddwo_pkg::S_DONE;
      ddwo_pkg::S_DONE:   if (out_free) state_d = ddwo_pkg::S_IDLE;
      default:            state_d = ddwo_pkg::S_IDLE;
    endcase
    go_d = (state_d != state_q) && (state_d != ddwo_pkg::S_IDLE) &&
           (state_d != ddwo_pkg::S_CORDIC) && (state_d != ddwo_pkg::S_DONE);
  end

  // operands of the shared unit for each step
  always_comb begin
    ar_cmd.start = go_q;
    ar_cmd.op    = ddwo_pkg::AR_MUL;
    ar_cmd.a     = '0;
    ar_cmd.b     = '0;
    unique case (state_q)
      ddwo_pkg::S_NOW: begin
        ar_cmd.a = 64'(sec_q);
        ar_cmd.b = ddwo_pkg::NS_PER_S;
      end
      ddwo_pkg::S_VL1: begin
        ar_cmd.a = 64'(rpm_l_q);
        ar_cmd.b = 64'(diam_q);
      end
      ddwo_pkg::S_VR1: begin
        ar_cmd.a = 64'(rpm_r_q);
        ar_cmd.b = 64'(diam_q);
      end
      ddwo_pkg::S_VL2, ddwo_pkg::S_VR2: begin
        ar_cmd.a = t_q;
        ar_cmd.b = ddwo_pkg::PI_Q32;
      end
      ddwo_pkg::S_VL3, ddwo_pkg::S_VR3: begin
        ar_cmd.op = ddwo_pkg::AR_DIV;
        ar_cmd.a  = t_q + ddwo_pkg::SPEED_HALF;
        ar_cmd.b  = ddwo_pkg::SPEED_DEN;
      end
      ddwo_pkg::S_W1: begin
        ar_cmd.a = (vr_q < vl_q) ? 64'(vl_q - vr_q) : 64'(vr_q - vl_q);
        ar_cmd.b = ddwo_pkg::UM_PER_M;
      end
      ddwo_pkg::S_W2: begin
        ar_cmd.op = ddwo_pkg::AR_DIV;
        ar_cmd.a  = t_q + 64'(tread_eff >> 1);
        ar_cmd.b  = 64'(tread_eff);
      end
      ddwo_pkg::S_P: begin
        ar_cmd.a = 64'(w_mag_q);
        ar_cmd.b = 64'(dt_mag_q);
      end
      ddwo_pkg::S_ANG: begin
        ar_cmd.a = t_q;
        ar_cmd.b = ddwo_pkg::KANG;
      end
      ddwo_pkg::S_XINIT: begin
        ar_cmd.a = 64'(vave_q);
        ar_cmd.b = ddwo_pkg::KINV_Q32;
      end
      ddwo_pkg::S_PX1: begin
        ar_cmd.a = 64'(vx_mag);
        ar_cmd.b = 64'(dt_mag_q);
      end
      ddwo_pkg::S_PY1: begin
        ar_cmd.a = 64'(vy_mag);
        ar_cmd.b = 64'(dt_mag_q);
      end
      ddwo_pkg::S_PX2, ddwo_pkg::S_PY2: begin
        ar_cmd.op = ddwo_pkg::AR_DIV;
        ar_cmd.a  = t_q + ddwo_pkg::NS_HALF;
        ar_cmd.b  = ddwo_pkg::NS_PER_S;
      end
      default: ;
    endcase
  end

  ddwo_serial_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ar_cmd),
    .rsp_o  (ar_rsp)
  );

  // control and state that reset clears or loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddwo_pkg::S_IDLE;
      go_q        <= 1'b0;
      frame_id_q  <= 29'd0;
      diam_q      <= 22'd500000;
      tread_q     <= 23'd1000000;
      first_q     <= 1'b1;
      last_q      <= '0;
      heading_q   <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ddwo_pkg::CFG_FRAME_ID: frame_id_q <= cfg_data_i;
          ddwo_pkg::CFG_DIAM:     diam_q     <= cfg_data_i[21:0];
          ddwo_pkg::CFG_TREAD:    tread_q    <= cfg_data_i[22:0];
          default: ;
        endcase
      end
      if (state_q == ddwo_pkg::S_VL1 && go_q) begin
        first_q <= 1'b0;
        last_q  <= now_q;
      end
      if (state_q == ddwo_pkg::S_ANG && ar_rsp.done) begin
        if (w_neg_q ^ dt_neg_q) heading_q <= heading_q - r_full[ANGLE_BITS-1:0];
        else                    heading_q <= heading_q + r_full[ANGLE_BITS-1:0];
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ddwo_pkg::S_DONE && out_free) begin
        pos_x_q     <= sat_add(pos_x_q, dx_q);
        pos_y_q     <= sat_add(pos_y_q, dy_q);
        out_valid_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && id_match) begin
      sec_q   <= stamp_sec_i;
      nsec_q  <= stamp_nsec_i;
      rpm_l_q <= left_rpm_i;
      rpm_r_q <= right_rpm_i;
    end
    // clamped time step, taken from the stamp before it is replaced
    if (state_q == ddwo_pkg::S_VL1 && go_q) begin
      dt_neg_q <= !first_q && diff[63];
      if (first_q) dt_mag_q <= '0;
      else if (diff[63]) dt_mag_q <= ((-diff) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                               : 32'(-diff);
      else dt_mag_q <= (diff > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
    end
    if (ar_rsp.done) begin
      unique case (state_q)
        ddwo_pkg::S_NOW: now_q <= ar_rsp.lo + 64'(nsec_q);
        ddwo_pkg::S_VL1, ddwo_pkg::S_VL2, ddwo_pkg::S_VR1, ddwo_pkg::S_VR2,
        ddwo_pkg::S_P, ddwo_pkg::S_PY1: t_q <= ar_rsp.lo;
        ddwo_pkg::S_VL3: vl_q <= ar_rsp.lo[22:0];
        ddwo_pkg::S_VR3: vr_q <= ar_rsp.lo[22:0];
        ddwo_pkg::S_W1: begin
          t_q      <= ar_rsp.lo;
          dw_neg_q <= (vr_q < vl_q);
          vave_q   <= vsum[23:1];
        end
        ddwo_pkg::S_W2: begin
          w_neg_q <= dw_neg_q;
          if (dw_neg_q) begin
            w_mag_q <= (wq > 64'h8000_0000) ? 32'h8000_0000 : wq[31:0];
            w_q     <= (wq > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-wq[31:0]);
          end else begin
            w_mag_q <= (wq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : wq[31:0];
            w_q     <= (wq > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(wq[31:0]);
          end
        end
        ddwo_pkg::S_XINIT: begin
          cx_q  <= flip ? -x0 : x0;
          cy_q  <= '0;
          cz_q  <= 33'(signed'(ang_adj));
          cnt_q <= '0;
        end
        ddwo_pkg::S_PX1: begin
          t_q   <= ar_rsp.lo;
          sgn_q <= vx_w[31] ^ dt_neg_q;
        end
        ddwo_pkg::S_PX2: dx_q <= sgn_q ? 32'(-ar_rsp.lo) : 32'(ar_rsp.lo);
        ddwo_pkg::S_PY2: dy_q <= (vy_w[31] ^ dt_neg_q) ? 32'(-ar_rsp.lo)
                                                      : 32'(ar_rsp.lo);
        default: ;
      endcase
    end
    // rotator iterations
    if (state_q == ddwo_pkg::S_CORDIC) begin
      cnt_q <= cnt_q + 5'd1;
      if (!cz_q[32]) begin
        cx_q <= cx_q - dxs;
        cy_q <= cy_q + dys;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + dxs;
        cy_q <= cy_q - dys;
        cz_q <= cz_q + at;
      end
    end
    // result capture
    if (state_q == ddwo_pkg::S_DONE && out_free) begin
      o_head_q <= signed'(ang32);
      o_vx_q   <= vx_w;
      o_vy_q   <= vy_w;
      o_w_q    <= w_q;
      o_sec_q  <= sec_q;
      o_nsec_q <= nsec_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign heading_o   = o_head_q;
  assign vel_x_o     = o_vx_q;
  assign vel_y_o     = o_vy_q;
  assign yaw_rate_o  = o_w_q;
  assign out_sec_o   = o_sec_q;
  assign out_nsec_o  = o_nsec_q;

  `ASSERT_IMPLY(a_rise_from_done, $rose(out_valid_q),
    $past(state_q) == ddwo_pkg::S_DONE, "result appeared outside the final step")
  `ASSERT_IMPLY(a_no_start_busy, ar_cmd.start, !ar_rsp.busy,
    "serial unit started while busy")
  `ASSERT_IMPLY(a_cordic_bound, state_q == ddwo_pkg::S_CORDIC,
    cnt_q < 5'(ddwo_pkg::CORDIC_STEPS), "rotator ran past its last step")

endmodule

>>> dv/diff_drive_wheel_odometry_tb.sv
// self-checking testbench of the differential-drive wheel odometry block
// depends on ddwo_pkg and diff_drive_wheel_odometry
module diff_drive_wheel_odometry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_W     = 48;
  localparam int unsigned LATENCY   = 1200;
  localparam longint      CYC_LIMIT = 8000000;
  localparam longint      DT_CLAMP  = 64'd4294967295;
  localparam logic [28:0] ID_MAX    = 29'h1FFF_FFFF;
  localparam logic [21:0] DIAM_MAX  = 22'h3F_FFFF;
  localparam logic [22:0] TREAD_MAX = 23'h7F_FFFF;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [31:0]             heading;
    logic [31:0]             vel_x;
    logic [31:0]             vel_y;
    logic [31:0]             yaw_rate;
    logic [30:0]             sec;
    logic [29:0]             nsec;
  } pose_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [28:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [28:0] can_id_i;
  logic [7:0] left_rpm_i, right_rpm_i;
  logic [30:0] stamp_sec_i;
  logic [29:0] stamp_nsec_i;
  logic out_valid_o, out_ready_i;
  logic signed [POS_W-1:0] pos_x_o, pos_y_o;
  logic signed [31:0] heading_o, vel_x_o, vel_y_o, yaw_rate_o;
  logic [30:0] out_sec_o;
  logic [29:0] out_nsec_o;

  diff_drive_wheel_odometry DUT (.*);

  // predictor copy of configuration and state
  logic [28:0] cfg_frame_id;
  logic [21:0] cfg_diam;
  logic [22:0] cfg_tread;
  logic [31:0] head_acc;
  longint      pos_x_sum, pos_y_sum;
  logic [63:0] prev_stamp;
  bit          first_frame;

  pose_t  pose_q[$];
  int     fail_cnt;
  longint cyc_cnt;
  int     send_idle_pct, recv_idle_pct, recv_hold;
  int     odo_frames;
  logic [63:0] cur_ns;

  int unsigned atan_q32[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1};

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("[diff_drive_wheel_odometry] ERROR");
      $finish;
    end
  end

  // wheel speed in q16 m/s
  function automatic longint wheel_q16(logic [7:0] rpm);
    logic [63:0] t;
    t = 64'(rpm) * 64'(cfg_diam) * ddwo_pkg::PI_Q32 + ddwo_pkg::SPEED_HALF;
    return longint'(t / ddwo_pkg::SPEED_DEN);
  endfunction

  // divide with rounding half away from zero
  function automatic longint div_half_away(longint n, logic [63:0] d);
    logic [63:0] u;
    if (n >= 0) begin
      u = n;
      return longint'((u + d / 2) / d);
    end
    u = -n;
    return -longint'((u + d / 2) / d);
  endfunction

  function automatic longint pos_sat(longint a, longint d);
    longint s, hi, lo;
    hi = (64'sd1 <<< (POS_W - 1)) - 1;
    lo = -hi - 1;
    s = a + d;
    if (s > hi) return hi;
    if (s < lo) return lo;
    return s;
  endfunction

  // cordic rotation of (v, 0) by a binary angle
  function automatic void rotate_speed(longint v, logic [31:0] ang,
                                       output longint vx, output longint vy);
    longint x, y, z, dx, dy;
    logic [63:0] t;
    logic [31:0] a;
    t = 64'(v) * ddwo_pkg::KINV_Q32 + 64'd32768;
    x = longint'(t >> 16);
    y = 0;
    a = ang;
    if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      x = -x;
      a = a + 32'h8000_0000;
    end
    z = longint'($signed(a));
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_q32[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_q32[i]);
      end
    end
    vx = (x + 32768) >>> 16;
    vy = (y + 32768) >>> 16;
  endfunction

  // advance the odometry state by one accepted frame
  task automatic track_frame(logic [28:0] id, logic [7:0] lrpm, logic [7:0] rrpm,
                             logic [30:0] sec, logic [29:0] nsec);
    logic [63:0] now, mag, r, tread;
    logic [127:0] prod;
    longint vl, vr, vave, w, dt, p, vx, vy;
    pose_t e;
    if (id != cfg_frame_id) return;
    now = 64'(sec) * ddwo_pkg::NS_PER_S + 64'(nsec);
    tread = (cfg_tread == 0) ? 64'd1 : 64'(cfg_tread);
    vl = wheel_q16(lrpm);
    vr = wheel_q16(rrpm);
    vave = (vl + vr + 1) >>> 1;
    w = div_half_away((vr - vl) * 1000000, tread);
    if (w > 64'sd2147483647) w = 64'sd2147483647;
    if (w < -64'sd2147483648) w = -64'sd2147483648;
    dt = first_frame ? 0 : longint'(now) - longint'(prev_stamp);
    if (dt > DT_CLAMP) dt = DT_CLAMP;
    if (dt < -DT_CLAMP) dt = -DT_CLAMP;
    first_frame = 1'b0;
    prev_stamp = now;
    // heading integration
    p = w * dt;
    mag = (p < 0) ? -p : p;
    prod = 128'(mag) * 128'(ddwo_pkg::KANG);
    r = (prod[127:64] + 64'd32768) >> 16;
    if (p < 0) head_acc = head_acc - r[31:0];
    else head_acc = head_acc + r[31:0];
    rotate_speed(vave, head_acc, vx, vy);
    pos_x_sum = pos_sat(pos_x_sum, div_half_away(vx * dt, ddwo_pkg::NS_PER_S));
    pos_y_sum = pos_sat(pos_y_sum, div_half_away(vy * dt, ddwo_pkg::NS_PER_S));
    e.pos_x = pos_x_sum[POS_W-1:0];
    e.pos_y = pos_y_sum[POS_W-1:0];
    e.heading = head_acc;
    e.vel_x = vx[31:0];
    e.vel_y = vy[31:0];
    e.yaw_rate = w[31:0];
    e.sec = sec;
    e.nsec = nsec;
    pose_q.push_back(e);
    odo_frames++;
  endtask

  // one frame request; valid stays high on return
  task automatic send_frame(logic [28:0] id, logic [7:0] lrpm, logic [7:0] rrpm,
                            logic [30:0] sec, logic [29:0] nsec);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    can_id_i <= id;
    left_rpm_i <= lrpm;
    right_rpm_i <= rrpm;
    stamp_sec_i <= sec;
    stamp_nsec_i <= nsec;
    do @(posedge clk_i); while (!in_ready_o);
    track_frame(id, lrpm, rrpm, sec, nsec);
    @(negedge clk_i);
  endtask

  // stop sending and wait until the block is idle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [28:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ddwo_pkg::CFG_FRAME_ID: cfg_frame_id = data;
      ddwo_pkg::CFG_DIAM:     cfg_diam = data[21:0];
      ddwo_pkg::CFG_TREAD:    cfg_tread = data[22:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // frame with a stamp dt ns after the previous one
  task automatic send_after(logic [63:0] dt, logic [7:0] lrpm, logic [7:0] rrpm);
    cur_ns = cur_ns + dt;
    send_frame(cfg_frame_id, lrpm, rrpm, 31'(cur_ns / ddwo_pkg::NS_PER_S),
               30'(cur_ns % ddwo_pkg::NS_PER_S));
  endtask

  // receiver: random stalls and forced hold-offs
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (recv_hold > 0) begin
      out_ready_i <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pose_q.size() == 0) begin
        $display("%0t: result request with no frame pending", $time);
        fail_cnt++;
      end else begin
        e = pose_q.pop_front();
        if (pos_x_o !== e.pos_x) begin
          $display("%0t: pos_x exp %0d got %0d", $time, e.pos_x, pos_x_o); fail_cnt++;
        end
        if (pos_y_o !== e.pos_y) begin
          $display("%0t: pos_y exp %0d got %0d", $time, e.pos_y, pos_y_o); fail_cnt++;
        end
        if (heading_o !== e.heading) begin
          $display("%0t: heading exp %h got %h", $time, e.heading, heading_o); fail_cnt++;
        end
        if (vel_x_o !== e.vel_x) begin
          $display("%0t: vel_x exp %h got %h", $time, e.vel_x, vel_x_o); fail_cnt++;
        end
        if (vel_y_o !== e.vel_y) begin
          $display("%0t: vel_y exp %h got %h", $time, e.vel_y, vel_y_o); fail_cnt++;
        end
        if (yaw_rate_o !== e.yaw_rate) begin
          $display("%0t: yaw_rate exp %h got %h", $time, e.yaw_rate, yaw_rate_o);
          fail_cnt++;
        end
        if (out_sec_o !== e.sec || out_nsec_o !== e.nsec) begin
          $display("%0t: stamp exp %0d.%0d got %0d.%0d", $time, e.sec, e.nsec,
                   out_sec_o, out_nsec_o);
          fail_cnt++;
        end
      end
    end
  end

  // default registers: first frame, rpm extremes, time anomalies, dropped ids
  task automatic test_default_frames();
    send_frame(29'd0, 8'd0, 8'd0, 31'd0, 30'd0);
    send_after(64'd100000000, 8'd255, 8'd255);
    send_after(64'd50000000, 8'd0, 8'd255);
    send_after(64'd50000000, 8'd255, 8'd0);
    send_after(64'd20000000, 8'd170, 8'd85);
    send_frame(29'd1, 8'd10, 8'd20, 31'd5, 30'd0);
    send_frame(ID_MAX, 8'd10, 8'd20, 31'd5, 30'd0);
    // time going backwards
    cur_ns = cur_ns - 64'd150000000;
    send_after(64'd0, 8'd100, 8'd40);
    // long gap is clamped
    send_after(64'd100000000000, 8'd200, 8'd30);
    // nanoseconds beyond one second
    send_frame(29'd0, 8'd60, 8'd61, 31'd100, 30'h3FFF_FFFF);
    send_frame(29'd0, 8'd61, 8'd60, 31'h7FFF_FFFF, 30'h3FFF_FFFF);
    send_frame(29'd0, 8'd1, 8'd2, 31'h7FFF_FFFF, 30'd0);
    cur_ns = 64'd200000000000;
    send_after(64'd0, 8'd5, 8'd7);
    drain_results();
  endtask

  // register extremes: zero and full diameter and tread, full frame id
  task automatic test_register_extremes();
    cfg_write(ddwo_pkg::CFG_TREAD, 29'd0);
    cfg_write(ddwo_pkg::CFG_DIAM, 29'(DIAM_MAX));
    send_after(64'd10000000, 8'd0, 8'd255);
    send_after(64'd10000000, 8'd255, 8'd0);
    drain_results();
    cfg_write(ddwo_pkg::CFG_DIAM, 29'd0);
    cfg_write(ddwo_pkg::CFG_TREAD, 29'(TREAD_MAX));
    send_after(64'd10000000, 8'd255, 8'd3);
    drain_results();
    cfg_write(ddwo_pkg::CFG_FRAME_ID, ID_MAX);
    cfg_write(ddwo_pkg::CFG_DIAM, 29'd1);
    cfg_write(ddwo_pkg::CFG_TREAD, 29'd1);
    send_frame(29'd0, 8'd9, 8'd9, 31'd1, 30'd0);
    send_after(64'd1000000, 8'd255, 8'd254);
    cfg_write_idle_wait();
  endtask

  task automatic cfg_write_idle_wait();
    drain_results();
  endtask

  task automatic random_config();
    logic [28:0] id;
    case ($urandom_range(3))
      0: id = 29'd0;
      1: id = ID_MAX;
      default: id = 29'($urandom);
    endcase
    cfg_write(ddwo_pkg::CFG_FRAME_ID, id);
    cfg_write(ddwo_pkg::CFG_DIAM, ($urandom_range(3) == 0) ? 29'(DIAM_MAX) :
              29'($urandom_range(50000, 1500000)));
    cfg_write(ddwo_pkg::CFG_TREAD, ($urandom_range(3) == 0) ? 29'($urandom) :
              29'($urandom_range(200000, 2000000)));
  endtask

  // random frames: mostly steady driving, some jumps and foreign ids
  task automatic test_random_drive(int n_frames, int s_pct, int r_pct);
    int target, k;
    logic [28:0] id;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = odo_frames + n_frames;
    while (odo_frames < target) begin
      k = $urandom_range(99);
      if (k < 10) begin
        id = 29'($urandom);
        send_frame(id, 8'($urandom), 8'($urandom), 31'($urandom), 30'($urandom));
      end else if (k < 16) begin
        send_frame(cfg_frame_id, 8'($urandom), 8'($urandom),
                   31'($urandom), 30'($urandom));
        cur_ns = 64'(stamp_sec_i) * ddwo_pkg::NS_PER_S + 64'(stamp_nsec_i);
        if (cur_ns > 64'd2000000000000000000) cur_ns = 64'd1000000000000;
      end else if (k < 20) begin
        cur_ns = cur_ns - 64'($urandom_range(1000000000));
        send_after(64'd0, 8'($urandom), 8'($urandom));
      end else if (k < 23) begin
        send_after(64'($urandom_range(20)) * ddwo_pkg::NS_PER_S, 8'($urandom),
                   8'($urandom));
      end else begin
        send_after(64'($urandom_range(200000000)), 8'($urandom), 8'($urandom));
      end
    end
    drain_results();
  endtask

  // receiver holds off while frames keep coming, then sender waits for all
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 4000;
    repeat (6) send_after(64'd5000000, 8'($urandom), 8'($urandom));
    drain_results();
    repeat (3) send_after(64'd5000000, 8'($urandom), 8'($urandom));
    drain_results();
  endtask

  initial begin
    fail_cnt = 0;
    cyc_cnt = 0;
    odo_frames = 0;
    recv_hold = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_ns = 0;
    cfg_frame_id = 29'd0;
    cfg_diam = 22'd500000;
    cfg_tread = 23'd1000000;
    head_acc = 0;
    pos_x_sum = 0;
    pos_y_sum = 0;
    prev_stamp = 0;
    first_frame = 1'b1;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    can_id_i = '0;
    left_rpm_i = '0;
    right_rpm_i = '0;
    stamp_sec_i = '0;
    stamp_nsec_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_frames();
    test_register_extremes();
    test_backpressure();
    random_config();
    test_random_drive(400, 23, 73);
    random_config();
    test_random_drive(400, 73, 23);
    random_config();
    test_random_drive(400, 0, 0);

    repeat (LATENCY) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[diff_drive_wheel_odometry] OK");
    end else begin
      $display("[diff_drive_wheel_odometry] ERROR");
    end
    $finish;
  end

endmodule

>>> diff_drive_wheel_odometry.f
+incdir+hdl
hdl/ddwo_pkg.sv
hdl/ddwo_serial_alu.sv
hdl/diff_drive_wheel_odometry.sv
dv/diff_drive_wheel_odometry_tb.sv
